// ===== rtl/lruc_pkg.sv =====
// ----------------------------------------------------------------------------
// lruc_pkg: shared types for the LRU set-associative cache with victim store
// Holds the input and result word structs and the operation codes.
// ----------------------------------------------------------------------------
package lruc_pkg;

  localparam logic [1:0] MODE_LOOKUP = 2'd0;
  localparam logic [1:0] MODE_TOUCH  = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  tid;
    logic [31:0] line_index;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        writeback_valid;
    logic [7:0]  writeback_thread;
    logic [31:0] writeback_index;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture the request and issue the set row read
    logic search;   // compare the row and the victim store
    logic update;   // write the row back and update the victim store
  } cmd_t;

endpackage

// ===== rtl/lruc_ram.sv =====
// ----------------------------------------------------------------------------
// lruc_ram: generic single-port RAM with registered read
// One address per cycle: it is read every cycle and also written when we is high.
// ----------------------------------------------------------------------------
module lruc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/lruc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lruc_ctrl: sequencing of one access
// Steps each word through read, search and update, then holds the result.
// ----------------------------------------------------------------------------
module lruc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lruc_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_SEARCH = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       take;

  // A new word is taken when idle or when the held result leaves this cycle.
  assign in_stall  = !((state == ST_IDLE) || (state == ST_OUT && !out_stall));
  assign take      = in_valid && !in_stall;
  assign out_valid = (state == ST_OUT);

  always_comb begin
    cmd.load   = take;
    cmd.search = (state == ST_SEARCH);
    cmd.update = (state == ST_UPDATE);
    state_next = state;
    case (state)
      ST_IDLE:   if (take) state_next = ST_READ;
      ST_READ:   state_next = ST_SEARCH;
      ST_SEARCH: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_OUT;
      ST_OUT: begin
        if (take) begin
          state_next = ST_READ;
        end else if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/lruc_dp.sv =====
// ----------------------------------------------------------------------------
// lruc_dp: tag row memory, set fill counts, victim store and result register
// A set row holds WAYS entries in recency order, slot 0 most recent.
// Each row word also carries the fill count of its set; a per-set flag marks
// rows written since reset, so an unwritten row reads as empty.
// ----------------------------------------------------------------------------
module lruc_dp #(
  parameter int SET_COUNT      = 64,
  parameter int WAYS           = 8,
  parameter int VICTIM_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  lruc_pkg::cmd_t cmd,
  input  lruc_pkg::req_t req,
  output lruc_pkg::rsp_t rsp
);

  localparam int SB    = $clog2(SET_COUNT + 1) - 1;  // floor(log2(SET_COUNT))
  localparam int SETS  = 1 << SB;
  localparam int SA    = (SB > 0) ? SB : 1;
  localparam int TW    = 32 - SB;                    // tag width
  localparam int EW    = TW + 8;                     // tag plus thread
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int FW    = $clog2(WAYS + 1);
  localparam int RW    = WAYS * EW + FW;             // row word with fill count
  localparam int VW    = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
  localparam int VFW   = $clog2(VICTIM_ENTRIES + 1);

  typedef struct packed {
    logic [TW-1:0] tag;
    logic [7:0]    thr;
  } ent_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  thr;
  } vent_t;

  lruc_pkg::req_t r;
  logic [SA-1:0]  set_idx;
  logic [TW-1:0]  tag;

  logic [RW-1:0] row_rd;
  logic [RW-1:0] row_wr;
  logic          row_we;
  ent_t          row [WAYS];
  ent_t          row_new [WAYS];

  logic [SETS-1:0] set_ok;
  logic [FW-1:0]   cur_fill;

  vent_t         vic [VICTIM_ENTRIES];
  logic [VFW-1:0] vfill;

  // Search results, registered between the search and update steps.
  logic          s_hit;
  logic [WW-1:0] s_pos;
  logic          v_hit;
  logic [VW-1:0] v_pos;

  assign set_idx = (SB > 0) ? SA'(r.line_index) : '0;
  assign tag     = TW'(r.line_index >> SB);
  assign cur_fill = set_ok[set_idx] ? row_rd[WAYS*EW +: FW] : '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r <= req;
    end
  end

  lruc_ram #(.WIDTH(RW), .DEPTH(SETS)) u_rows (
    .clk   (clk),
    .we    (row_we),
    .addr  ((SB > 0) ? (cmd.load ? SA'(req.line_index) : set_idx) : '0),
    .wdata (row_wr),
    .rdata (row_rd)
  );

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      row[i] = row_rd[i*EW +: EW];
    end
  end

  // Parallel compare; the lowest position is the most recent match.
  logic          m_hit;
  logic [WW-1:0] m_pos;
  logic          mv_hit;
  logic [VW-1:0] mv_pos;
  always_comb begin
    m_hit = 1'b0;
    m_pos = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (FW'(i) < cur_fill && row[i].tag == tag && row[i].thr == r.tid) begin
        m_hit = 1'b1;
        m_pos = WW'(i);
      end
    end
    mv_hit = 1'b0;
    mv_pos = '0;
    for (int i = VICTIM_ENTRIES - 1; i >= 0; i--) begin
      if (VFW'(i) < vfill && vic[i].key == r.line_index && vic[i].thr == r.tid) begin
        mv_hit = 1'b1;
        mv_pos = VW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      s_hit <= m_hit;
      s_pos <= m_pos;
      v_hit <= mv_hit;
      v_pos <= mv_pos;
    end
  end

  // Row rewrite: promote the hit entry, or insert the new one at slot 0.
  logic ins;
  logic full_row;
  ent_t lru;
  always_comb begin
    ins      = (r.mode == lruc_pkg::MODE_LOOKUP) && !s_hit;
    full_row = (cur_fill >= FW'(WAYS));
    lru      = row[WAYS-1];
    for (int i = 0; i < WAYS; i++) begin
      row_new[i] = row[i];
    end
    if (s_hit && (r.mode == lruc_pkg::MODE_LOOKUP || r.mode == lruc_pkg::MODE_TOUCH)) begin
      row_new[0] = row[s_pos];
      for (int i = 1; i < WAYS; i++) begin
        if (WW'(i) <= s_pos) row_new[i] = row[i-1];
      end
    end else if (ins) begin
      row_new[0].tag = tag;
      row_new[0].thr = r.tid;
      for (int i = 1; i < WAYS; i++) begin
        row_new[i] = row[i-1];
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      row_wr[i*EW +: EW] = row_new[i];
    end
    row_wr[WAYS*EW +: FW] = (ins && !full_row) ? cur_fill + FW'(1) : cur_fill;
    row_we = cmd.update;
  end

  // Victim store update and result.
  logic  vins;
  vent_t vnew;
  always_comb begin
    vins     = cmd.update && ins && full_row;
    vnew.key = (32'(lru.tag) << SB) | 32'(set_idx);
    vnew.thr = lru.thr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vfill  <= '0;
      set_ok <= '0;
    end else if (cmd.update) begin
      set_ok[set_idx] <= 1'b1;
      if (vins) begin
        if (vfill < VFW'(VICTIM_ENTRIES)) vfill <= vfill + VFW'(1);
      end else if (r.mode == lruc_pkg::MODE_REMOVE && v_hit) begin
        vfill <= vfill - VFW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      if (vins) begin
        vic[0] <= vnew;
        for (int i = 1; i < VICTIM_ENTRIES; i++) vic[i] <= vic[i-1];
      end else if (r.mode == lruc_pkg::MODE_TOUCH && !s_hit && v_hit) begin
        vic[0] <= vic[v_pos];
        for (int i = 1; i < VICTIM_ENTRIES; i++) begin
          if (VW'(i) <= v_pos) vic[i] <= vic[i-1];
        end
      end else if (r.mode == lruc_pkg::MODE_REMOVE && v_hit) begin
        for (int i = 0; i < VICTIM_ENTRIES - 1; i++) begin
          if (VW'(i) >= v_pos) vic[i] <= vic[i+1];
        end
      end
      rsp.hit <= ((r.mode == lruc_pkg::MODE_LOOKUP) && s_hit) ||
                 ((r.mode == lruc_pkg::MODE_REMOVE) && v_hit);
      if (vins && vfill >= VFW'(VICTIM_ENTRIES)) begin
        rsp.writeback_valid  <= 1'b1;
        rsp.writeback_thread <= vic[VICTIM_ENTRIES-1].thr;
        rsp.writeback_index  <= vic[VICTIM_ENTRIES-1].key;
      end else begin
        rsp.writeback_valid  <= 1'b0;
        rsp.writeback_thread <= '0;
        rsp.writeback_index  <= '0;
      end
    end
  end

endmodule

// ===== rtl/lru_set_assoc_cache_with_victim.sv =====
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_with_victim: LRU set-associative tag store with an
// LRU victim store
// ----------------------------------------------------------------------------
// Channel | Direction | Word
// in      | input     | lruc_pkg::req_t (mode, tid, line_index)
// out     | output    | lruc_pkg::rsp_t (hit, writeback fields)
//
// Each word is stepped through in order: the set row is read from the row memory, the
// row and victim store are compared, the row and victim store are updated,
// and the result is presented. A new word is taken in the cycle the previous
// result leaves. Reset clears the per-set row flags and the victim fill count;
// a set row not yet written since reset reads as empty.
// out_stall holds the result and blocks new input until it is taken.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_with_victim #(
  parameter int SET_COUNT      = 64,
  parameter int WAYS           = 8,
  parameter int VICTIM_ENTRIES = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  lruc_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lruc_pkg::rsp_t out_data
);

  lruc_pkg::cmd_t cmd;

  // The controller only sequences; all storage lives in the datapath.
  lruc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lruc_dp #(
    .SET_COUNT      (SET_COUNT),
    .WAYS           (WAYS),
    .VICTIM_ENTRIES (VICTIM_ENTRIES)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (in_data),
    .rsp (out_data)
  );

endmodule
